FILE: hw/rtl/wct_pkg.sv
package wct_pkg;

  localparam int TEX_SIZE = 64;
  localparam int TEX_LOG2 = $clog2(TEX_SIZE);

  localparam int TEXEL_W    = 6;
  localparam int ROW_W      = 12;
  localparam int SCREEN_W   = 13;
  localparam int COLOR_W    = 24;
  localparam int FIX_W      = 32;
  localparam int LH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // The dividend TEX_SIZE << 16 has its single set bit at position 16 + TEX_LOG2.
  localparam int DIV_W = 17 + TEX_LOG2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ROW  = 1'b1;

  localparam logic [1:0] KIND_CEILING = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_FLOOR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR   = 2'd2;

endpackage

FILE: hw/rtl/wct_if.sv
interface wct_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        hit_side;
  logic        step_x_positive;
  logic        step_y_positive;
  logic [31:0] wall_distance;
  logic signed [31:0] ray_dir_x;
  logic signed [31:0] ray_dir_y;
  logic [31:0] player_x;
  logic [31:0] player_y;
  logic [15:0] line_height;
  logic [11:0] wall_top;
  logic [11:0] wall_bottom;

  modport source(output valid, action, hit_side, step_x_positive, step_y_positive,
                 wall_distance, ray_dir_x, ray_dir_y, player_x, player_y,
                 line_height, wall_top, wall_bottom, input ready);
  modport sink(input valid, action, hit_side, step_x_positive, step_y_positive,
               wall_distance, ray_dir_x, ray_dir_y, player_x, player_y,
               line_height, wall_top, wall_bottom, output ready);
endinterface

interface wct_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row;
  logic [1:0]  pixel_kind;
  logic [23:0] flat_color;
  logic [1:0]  texture_index;
  logic [5:0]  texel_x;
  logic [5:0]  texel_y;

  modport source(output valid, row, pixel_kind, flat_color, texture_index, texel_x,
                 texel_y, input ready);
  modport sink(input valid, row, pixel_kind, flat_color, texture_index, texel_x,
               texel_y, output ready);
endinterface

interface wct_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/wct_divider.sv
module wct_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wct_pkg::LH_W-1:0]    divisor,
  output logic                        done,
  output logic [wct_pkg::DIV_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(wct_pkg::DIV_W);
  localparam int REM_W = wct_pkg::LH_W + 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(wct_pkg::DIV_W - 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [wct_pkg::LH_W-1:0]  rem_r, rem_nxt;
  logic [wct_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          rem_sub;
  logic                      fits;

  // Restoring division of TEX_SIZE << 16, one quotient bit per cycle, MSB first.
  // The dividend has only its top bit set, so the incoming bit is a compare on the count.
  assign rem_sh  = {rem_r, (cnt_r == CNT_TOP)};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = (rem_sh >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_TOP;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[wct_pkg::LH_W-1:0] : rem_sh[wct_pkg::LH_W-1:0];
      q_nxt   = {q_r[wct_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/wall_column_texture_stepper.sv
// Textured wall column stepper for a raycaster.
// Input channel in_chan carries one item per transaction. An item with action
// set to load latches a new screen column and gives no result; the block then
// computes the texel column with the shared 32-bit multiplier, divides the
// texture size by the line height in an iterative divider and scales the start
// position with the same multiplier. A load keeps in_chan.ready low through
// states S_MULX, S_DIV and S_MULP, waiting in S_DIV for the one-bit-per-cycle divider.
// A row item gives one result on out_chan, the ceiling colour, a wall texel
// address or the floor colour for the next row of the column; row items past
// screen_height give no result. Results appear in the cycle after acceptance,
// from an output register.
// When out_chan stalls, the register holds its result and in_chan.ready drops
// until the result is taken. cfg_chan is always ready and writes screen_height,
// ceiling_color and floor_color; write it only while the block is idle.
// A synchronous reset (rst_n low) clears the column state, so rows before the
// first load are all floor, and sets screen_height to 480.
module wall_column_texture_stepper (
  input  logic       clk,
  input  logic       rst_n,
  wct_in_if.sink     in_chan,
  wct_out_if.source  out_chan,
  wct_cfg_if.sink    cfg_chan
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MULX = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_MULP = 2'd3;

  localparam int TL = wct_pkg::TEX_LOG2;

  logic [1:0] state_r, state_nxt;

  logic [wct_pkg::SCREEN_W-1:0] screen_height_r;
  logic [wct_pkg::COLOR_W-1:0]  ceiling_color_r;
  logic [wct_pkg::COLOR_W-1:0]  floor_color_r;

  logic [wct_pkg::SCREEN_W-1:0] row_counter_r;
  logic [wct_pkg::FIX_W-1:0]    texture_position_r;
  logic [wct_pkg::FIX_W-1:0]    texture_step_r;
  logic [wct_pkg::TEXEL_W-1:0]  column_texel_x_r;
  logic [1:0]                   chosen_texture_r;
  logic [wct_pkg::ROW_W-1:0]    slice_top_r;
  logic [wct_pkg::ROW_W-1:0]    slice_bottom_r;

  logic [wct_pkg::FIX_W-1:0]    dist_r;
  logic [wct_pkg::FIX_W-1:0]    dir_r;
  logic [15:0]                  pos_frac_r;
  logic [wct_pkg::LH_W-1:0]     lh_r;

  logic                         out_valid_r;
  logic [wct_pkg::ROW_W-1:0]    out_row_r;
  logic [1:0]                   out_kind_r;
  logic [wct_pkg::COLOR_W-1:0]  out_color_r;
  logic [1:0]                   out_tex_r;
  logic [wct_pkg::TEXEL_W-1:0]  out_tx_r;
  logic [wct_pkg::TEXEL_W-1:0]  out_ty_r;

  logic                         in_fire;
  logic                         load_fire;
  logic                         row_fire;
  logic                         row_live;
  logic                         div_done;
  logic [wct_pkg::DIV_W-1:0]    div_q;

  logic [wct_pkg::FIX_W-1:0]    mul_a;
  logic [wct_pkg::FIX_W-1:0]    mul_b;
  logic [wct_pkg::FIX_W-1:0]    mul_p;
  logic [15:0]                  hit_frac;
  logic [TL-1:0]                tex_col;
  logic signed [17:0]           base;

  assign in_chan.ready  = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign load_fire      = in_fire && (in_chan.action == wct_pkg::ACT_LOAD);
  assign row_fire       = in_fire && (in_chan.action == wct_pkg::ACT_ROW);
  assign row_live       = row_counter_r < screen_height_r;
  assign cfg_chan.ready = 1'b1;

  // Texture start row offset: top - screen/2 + height/2, at most 18 bits signed.
  assign base = $signed({6'b0, slice_top_r})
              - $signed({6'b0, screen_height_r[wct_pkg::SCREEN_W-1:1]})
              + $signed({3'b0, lh_r[wct_pkg::LH_W-1:1]});

  // The one multiplier serves both the hit point and the start position; only the
  // low 32 bits of each product matter, which are the same signed or unsigned.
  always_comb begin
    if (state_r == S_MULP) begin
      mul_a = {{14{base[17]}}, base};
      mul_b = texture_step_r;
    end else begin
      mul_a = dist_r;
      mul_b = dir_r;
    end
  end
  assign mul_p    = mul_a * mul_b;
  assign hit_frac = pos_frac_r + mul_p[31:16];
  assign tex_col  = hit_frac[15 -: TL];

  wct_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (load_fire),
    .divisor  (lh_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (load_fire) state_nxt = S_MULX;
      S_MULX:  state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_MULP;
      S_MULP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      screen_height_r    <= wct_pkg::SCREEN_W'(480);
      ceiling_color_r    <= '0;
      floor_color_r      <= '0;
      row_counter_r      <= '0;
      texture_position_r <= '0;
      texture_step_r     <= '0;
      column_texel_x_r   <= '0;
      chosen_texture_r   <= '0;
      slice_top_r        <= '0;
      slice_bottom_r     <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          wct_pkg::CFG_SCREEN_HEIGHT:
            screen_height_r <= cfg_chan.data[wct_pkg::SCREEN_W-1:0];
          wct_pkg::CFG_CEILING_COLOR: ceiling_color_r <= cfg_chan.data;
          wct_pkg::CFG_FLOOR_COLOR:   floor_color_r   <= cfg_chan.data;
          default: ;
        endcase
      end

      if (load_fire) begin
        chosen_texture_r <= in_chan.hit_side ? (in_chan.step_y_positive ? 2'd2 : 2'd1)
                                             : (in_chan.step_x_positive ? 2'd3 : 2'd0);
        slice_top_r      <= in_chan.wall_top;
        slice_bottom_r   <= in_chan.wall_bottom;
        row_counter_r    <= '0;
      end

      if (state_r == S_MULX) begin
        // Mirrored column: TEX_SIZE - 1 - tx is the complement of tx.
        column_texel_x_r <= wct_pkg::TEXEL_W'(~tex_col);
      end
      if ((state_r == S_DIV) && div_done) begin
        texture_step_r <= wct_pkg::FIX_W'(div_q);
      end
      if (state_r == S_MULP) begin
        texture_position_r <= mul_p;
      end

      if (row_fire && row_live) begin
        row_counter_r <= row_counter_r + 1'b1;
        if (({1'b0, slice_top_r} <= row_counter_r)
            && (row_counter_r < {1'b0, slice_bottom_r})) begin
          texture_position_r <= texture_position_r + texture_step_r;
        end
      end

      if (row_fire && row_live) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (load_fire) begin
      dist_r     <= in_chan.wall_distance;
      dir_r      <= in_chan.hit_side ? in_chan.ray_dir_x : in_chan.ray_dir_y;
      pos_frac_r <= in_chan.hit_side ? in_chan.player_x[15:0] : in_chan.player_y[15:0];
      lh_r       <= (in_chan.line_height == '0) ? wct_pkg::LH_W'(1) : in_chan.line_height;
    end

    if (row_fire && row_live) begin
      out_row_r <= row_counter_r[wct_pkg::ROW_W-1:0];
      if (row_counter_r < {1'b0, slice_top_r}) begin
        out_kind_r  <= wct_pkg::KIND_CEILING;
        out_color_r <= ceiling_color_r;
        out_tex_r   <= '0;
        out_tx_r    <= '0;
        out_ty_r    <= '0;
      end else if (row_counter_r < {1'b0, slice_bottom_r}) begin
        out_kind_r  <= wct_pkg::KIND_WALL;
        out_color_r <= '0;
        out_tex_r   <= chosen_texture_r;
        out_tx_r    <= column_texel_x_r;
        out_ty_r    <= wct_pkg::TEXEL_W'(texture_position_r[16 +: TL]);
      end else begin
        out_kind_r  <= wct_pkg::KIND_FLOOR;
        out_color_r <= floor_color_r;
        out_tex_r   <= '0;
        out_tx_r    <= '0;
        out_ty_r    <= '0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.row           = out_row_r;
  assign out_chan.pixel_kind    = out_kind_r;
  assign out_chan.flat_color    = out_color_r;
  assign out_chan.texture_index = out_tex_r;
  assign out_chan.texel_x       = out_tx_r;
  assign out_chan.texel_y       = out_ty_r;

endmodule

FILE: verif/wct_pixel_checker.sv
module wct_pixel_checker
  import wct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  wct_in_if    in_mon,
  wct_out_if   out_mon,
  wct_cfg_if   cfg_mon,
  output int   failures,
  output int   outstanding,
  output int   compared
);

  localparam logic [SCREEN_W-1:0] RESET_ROWS = 13'd480;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [1:0]         kind;
    logic [COLOR_W-1:0] color;
    logic [1:0]         tex;
    logic [TEXEL_W-1:0] tx;
    logic [TEXEL_W-1:0] ty;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic [SCREEN_W-1:0] screen_rows;
  logic [COLOR_W-1:0]  flat_ceiling;
  logic [COLOR_W-1:0]  flat_floor;

  logic [SCREEN_W-1:0] row_count;
  logic [FIX_W-1:0]    tex_pos;
  logic [FIX_W-1:0]    tex_step;
  logic [TEXEL_W-1:0]  col_texel;
  logic [1:0]          tex_choice;
  logic [ROW_W-1:0]    slice_top;
  logic [ROW_W-1:0]    slice_bottom;

  int fail_total = 0;
  int compare_total = 0;

  task automatic latch_column();
    logic [31:0] dir;
    logic [31:0] pos;
    logic [63:0] prod;
    logic [63:0] hit_x;
    logic [63:0] lh;
    logic [15:0] frac;
    longint      base;
    if (in_mon.hit_side == 1'b0) begin
      dir = in_mon.ray_dir_y;
      pos = in_mon.player_y;
      tex_choice = in_mon.step_x_positive ? 2'd3 : 2'd0;
    end else begin
      dir = in_mon.ray_dir_x;
      pos = in_mon.player_x;
      tex_choice = in_mon.step_y_positive ? 2'd2 : 2'd1;
    end
    // Signed direction times unsigned distance, kept modulo 2^64.
    prod = {32'd0, in_mon.wall_distance} * {{32{dir[31]}}, dir};
    frac = pos[15:0] + prod[31:16];
    hit_x = ({48'd0, frac} * 64'(TEX_SIZE)) >> 16;
    col_texel = TEXEL_W'(64'(TEX_SIZE) - hit_x - 64'd1);
    lh = (in_mon.line_height == '0) ? 64'd1 : {48'd0, in_mon.line_height};
    tex_step = FIX_W'((64'(TEX_SIZE) << 16) / lh);
    slice_top = in_mon.wall_top;
    slice_bottom = in_mon.wall_bottom;
    base = longint'(slice_top) - longint'(screen_rows / 2) + longint'(lh / 2);
    tex_pos = FIX_W'(base * longint'(tex_step));
    row_count = '0;
  endtask

  task automatic predict_pixel();
    pixel_t px;
    if (row_count < screen_rows) begin
      px = '0;
      px.row = row_count[ROW_W-1:0];
      if (row_count < {1'b0, slice_top}) begin
        px.kind = KIND_CEILING;
        px.color = flat_ceiling;
      end else if (row_count < {1'b0, slice_bottom}) begin
        px.kind = KIND_WALL;
        px.tex = tex_choice;
        px.tx = col_texel;
        px.ty = TEXEL_W'((tex_pos >> 16) & FIX_W'(TEX_SIZE - 1));
        tex_pos = tex_pos + tex_step;
      end else begin
        px.kind = KIND_FLOOR;
        px.color = flat_floor;
      end
      expected_pixels.push_back(px);
      row_count = row_count + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      screen_rows = RESET_ROWS;
      flat_ceiling = '0;
      flat_floor = '0;
      row_count = '0;
      tex_pos = '0;
      tex_step = '0;
      col_texel = '0;
      tex_choice = '0;
      slice_top = '0;
      slice_bottom = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SCREEN_HEIGHT: screen_rows = cfg_mon.data[SCREEN_W-1:0];
          CFG_CEILING_COLOR: flat_ceiling = cfg_mon.data;
          CFG_FLOOR_COLOR:   flat_floor = cfg_mon.data;
          default: ;
        endcase
      end
      // The output register is loaded in the cycle after its input is taken, so results are
      // matched before this cycle's input transaction adds an expectation.
      if (out_mon.valid && out_mon.ready) begin
        got.row = out_mon.row;
        got.kind = out_mon.pixel_kind;
        got.color = out_mon.flat_color;
        got.tex = out_mon.texture_index;
        got.tx = out_mon.texel_x;
        got.ty = out_mon.texel_y;
        if (expected_pixels.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result row %0d kind %0d color %06h tex %0d x %0d y %0d",
                   $time, got.row, got.kind, got.color, got.tex, got.tx, got.ty);
        end else begin
          want = expected_pixels.pop_front();
          compare_total++;
          if (got.row !== want.row || got.kind !== want.kind || got.color !== want.color ||
              got.tex !== want.tex || got.tx !== want.tx || got.ty !== want.ty) begin
            fail_total++;
            $display("%0t: pixel mismatch, expected row %0d kind %0d color %06h ", $time,
                     want.row, want.kind, want.color,
                     "tex %0d x %0d y %0d, got row %0d kind %0d color %06h ",
                     want.tex, want.tx, want.ty, got.row, got.kind, got.color,
                     "tex %0d x %0d y %0d", got.tex, got.tx, got.ty);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_LOAD) begin
          latch_column();
        end else begin
          predict_pixel();
        end
      end
    end
    failures <= fail_total;
    outstanding <= expected_pixels.size();
    compared <= compare_total;
  end

endmodule

FILE: verif/testbench.sv
module testbench;
  import wct_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES = 80;
  localparam int VIEW_ROWS = 48;

  typedef struct {
    logic        action;
    logic        hit_side;
    logic        step_x_positive;
    logic        step_y_positive;
    logic [31:0] wall_distance;
    logic [31:0] ray_dir_x;
    logic [31:0] ray_dir_y;
    logic [31:0] player_x;
    logic [31:0] player_y;
    logic [15:0] line_height;
    logic [11:0] wall_top;
    logic [11:0] wall_bottom;
  } ray_item_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   jitter_on = 1'b1;
  bit   hold_armed = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   loads_sent = 0;
  int   rows_sent = 0;
  int   random_items = 0;
  int   screen_rows = 480;
  int   fail_count;
  int   expect_count;
  int   checked_count;

  wct_in_if  in_chan();
  wct_out_if out_chan();
  wct_cfg_if cfg_chan();

  wall_column_texture_stepper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  wct_pixel_checker pixel_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_mon     (cfg_chan),
    .failures    (fail_count),
    .outstanding (expect_count),
    .compared    (checked_count)
  );

  always #HALF_PERIOD clk = ~clk;

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_chan.ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= STALL_CYCLES;
    end else begin
      out_chan.ready <= !jitter_on || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input ray_item_t it);
    if (jitter_on && $urandom_range(99) < 12) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= it.action;
    in_chan.hit_side <= it.hit_side;
    in_chan.step_x_positive <= it.step_x_positive;
    in_chan.step_y_positive <= it.step_y_positive;
    in_chan.wall_distance <= it.wall_distance;
    in_chan.ray_dir_x <= it.ray_dir_x;
    in_chan.ray_dir_y <= it.ray_dir_y;
    in_chan.player_x <= it.player_x;
    in_chan.player_y <= it.player_y;
    in_chan.line_height <= it.line_height;
    in_chan.wall_top <= it.wall_top;
    in_chan.wall_bottom <= it.wall_bottom;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (it.action == ACT_LOAD) begin
      loads_sent++;
    end else begin
      rows_sent++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx == CFG_SCREEN_HEIGHT) screen_rows = value[SCREEN_W-1:0];
  endtask

  // Waits out every pending result, then a margin for a load still in the divider.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expect_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [23:0] rows_word, input logic [23:0] ceil_rgb,
                           input logic [23:0] floor_rgb);
    settle();
    write_reg(CFG_SCREEN_HEIGHT, rows_word);
    write_reg(CFG_CEILING_COLOR, ceil_rgb);
    write_reg(CFG_FLOOR_COLOR, floor_rgb);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic ray_item_t random_fields();
    ray_item_t it;
    it.action = 1'($urandom_range(1));
    it.hit_side = 1'($urandom_range(1));
    it.step_x_positive = 1'($urandom_range(1));
    it.step_y_positive = 1'($urandom_range(1));
    it.wall_distance = $urandom();
    it.ray_dir_x = $urandom();
    it.ray_dir_y = $urandom();
    it.player_x = $urandom();
    it.player_y = $urandom();
    it.line_height = 16'($urandom());
    it.wall_top = 12'($urandom());
    it.wall_bottom = 12'($urandom());
    return it;
  endfunction

  function automatic ray_item_t row_item();
    ray_item_t it;
    it = random_fields();
    it.action = ACT_ROW;
    return it;
  endfunction

  function automatic ray_item_t make_column(input logic side, input logic sx, input logic sy,
                                            input logic [31:0] wall_dist,
                                            input logic [31:0] dx,
                                            input logic [31:0] dy, input logic [31:0] px,
                                            input logic [31:0] py, input logic [15:0] lh,
                                            input logic [11:0] top, input logic [11:0] bottom);
    ray_item_t it;
    it.action = ACT_LOAD;
    it.hit_side = side;
    it.step_x_positive = sx;
    it.step_y_positive = sy;
    it.wall_distance = wall_dist;
    it.ray_dir_x = dx;
    it.ray_dir_y = dy;
    it.player_x = px;
    it.player_y = py;
    it.line_height = lh;
    it.wall_top = top;
    it.wall_bottom = bottom;
    return it;
  endfunction

  // Mostly a wall slice centered on the visible rows, as a raycaster would
  // produce; now and then odd heights or arbitrary bounds.
  function automatic ray_item_t shaped_column();
    ray_item_t it;
    int view;
    int lh;
    int half;
    it = random_fields();
    it.action = ACT_LOAD;
    view = (screen_rows > VIEW_ROWS) ? VIEW_ROWS : screen_rows;
    case ($urandom_range(9))
      0: lh = 0;
      1: lh = 65535;
      2: lh = $urandom_range(65535);
      default: lh = $urandom_range(1, 2 * view + 2);
    endcase
    it.line_height = 16'(lh);
    half = view / 2;
    if ($urandom_range(9) < 8) begin
      it.wall_top = (lh / 2 > half) ? 12'd0 : 12'(half - lh / 2);
      it.wall_bottom = (half + lh / 2 > view) ? 12'(view) : 12'(half + lh / 2);
    end
    if ($urandom_range(3) != 0) it.wall_distance = $urandom_range(32'h0010_0000, 32'h100);
    return it;
  endfunction

  task automatic random_phase(input logic [23:0] rows_word, input int budget);
    int used;
    int view;
    int n;
    configure(rows_word, 24'($urandom()), 24'($urandom()));
    // The long hold-off starts only once items flow again, so the input backs up.
    if (hold_armed) begin
      hold_req <= !hold_req;
      hold_armed = 1'b0;
    end
    used = 0;
    while (used < budget) begin
      send_item(shaped_column());
      view = (screen_rows > VIEW_ROWS) ? VIEW_ROWS : screen_rows;
      if (screen_rows > view) begin
        n = $urandom_range(view / 2, view);
      end else begin
        n = view + $urandom_range(0, 2);
      end
      // Sometimes the column is cut short by an early reload.
      if ($urandom_range(9) == 0) n = $urandom_range(0, view);
      repeat (n) send_item(row_item());
      used += 1 + ((n < screen_rows) ? n : screen_rows);
    end
    random_items += used;
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.action <= ACT_LOAD;
    in_chan.hit_side <= 1'b0;
    in_chan.step_x_positive <= 1'b0;
    in_chan.step_y_positive <= 1'b0;
    in_chan.wall_distance <= '0;
    in_chan.ray_dir_x <= '0;
    in_chan.ray_dir_y <= '0;
    in_chan.player_x <= '0;
    in_chan.player_y <= '0;
    in_chan.line_height <= '0;
    in_chan.wall_top <= '0;
    in_chan.wall_bottom <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= CFG_SCREEN_HEIGHT;
    cfg_chan.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rows before any column is loaded come out as floor.
    repeat (2) send_item(row_item());

    // Six rows; the upper bits of the height word must be dropped.
    configure(24'hFFE006, 24'hFFFFFF, 24'h000000);
    // Zero line height and a negative start position.
    send_item(make_column(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h0, 32'hFFFF_FFFF, 16'h0000, 12'd2, 12'd4));
    repeat (7) send_item(row_item());
    // Top below bottom leaves no wall at all.
    send_item(make_column(1'b1, 1'b0, 1'b1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 32'h0, 16'hFFFF, 12'hFFF, 12'h000));
    repeat (3) send_item(row_item());
    send_item(make_column(1'b0, 1'b0, 1'b1, 32'h0001_8000, 32'h0000_4000, 32'hFFFF_C000,
                          32'h0003_2000, 32'h0002_F000, 16'd1, 12'd0, 12'hFFF));
    repeat (2) send_item(row_item());
    send_item(make_column(1'b1, 1'b1, 1'b0, 32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000,
                          32'h0004_8000, 32'h0000_0001, 16'd3, 12'd1, 12'd5));
    repeat (2) send_item(row_item());
    // An empty screen gives no rows at all.
    configure(24'd0, 24'h000000, 24'hFFFFFF);
    send_item(shaped_column());
    repeat (2) send_item(row_item());
    configure(24'd1, 24'h000000, 24'hFFFFFF);
    send_item(shaped_column());
    repeat (2) send_item(row_item());

    random_phase(24'd24, 90);
    hold_armed = 1'b1;
    random_phase(24'd40, 90);
    random_phase(24'd4096, 90);
    jitter_on <= 1'b0;
    random_phase(24'd17, 80);
    jitter_on <= 1'b1;
    random_phase(24'd1, 40);
    random_phase(24'd33, 90);
    random_phase(24'($urandom_range(2, 64)), 90);
    random_phase(24'd0, 10);

    // Tallest screen with a tall wall slice starting below the top rows.
    configure(24'd8191, 24'($urandom()), 24'($urandom()));
    send_item(make_column(1'b0, 1'b1, 1'b1, $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), 16'd3900, 12'd20, 12'd4000));
    repeat (40) send_item(row_item());

    settle();
    $display("Covered %0d column loads and %0d row transactions, %0d pixels compared.",
             loads_sent, rows_sent, checked_count);
    $display("Screen heights from 0 to 8191, with a long result stall and an idle-free stretch.");
    if (fail_count == 0 && expect_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wct_pkg.sv
hw/rtl/wct_if.sv
hw/rtl/wct_divider.sv
hw/rtl/wall_column_texture_stepper.sv
verif/wct_pixel_checker.sv
verif/testbench.sv
